[sv/rlag_pkg.sv]
// Package of types, codes and tables shared by the range/light result block.
package rlag_pkg;

  typedef enum logic [1:0] {
    CMD_RANGE_DONE    = 2'd0,
    CMD_RANGE_TIMEOUT = 2'd1,
    CMD_LIGHT_DONE    = 2'd2,
    CMD_LIGHT_TIMEOUT = 2'd3
  } cmd_e;

  // Register indexes on the configuration port (byte address is 4*index).
  localparam logic REG_RANGE_SCALE = 1'b0;
  localparam logic REG_LOW_THRESH  = 1'b1;

  localparam logic [1:0]  RANGE_SCALE_RESET = 2'd1;
  localparam logic [15:0] LOW_THRESH_RESET  = 16'd10000;
  localparam logic [15:0] COUNT_SATURATED   = 16'hFFFF;
  localparam logic [2:0]  GAIN_BOTTOM       = 3'd0;
  localparam logic [2:0]  GAIN_TOP          = 3'd7;

  // One accepted measurement word, with the gain it was taken under.
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  range_raw;
    logic [7:0]  range_status;
    logic [15:0] light_count;
    logic [1:0]  range_scale;
    logic [2:0]  gain_used;
    logic [2:0]  gain_after;
  } stage_t;

  // One finished result word.
  typedef struct packed {
    logic        result_kind;
    logic        result_valid;
    logic        tmo_flag;
    logic [9:0]  distance_mm;
    logic [3:0]  range_error;
    logic [22:0] lux_q8;
    logic [2:0]  gain_used;
    logic [2:0]  gain_after;
  } result_t;

  // round(0.32 * 2^24 / gain) for each step of the gain ladder.
  function automatic logic [22:0] lux_coef(input logic [2:0] g);
    logic [22:0] c;
    case (g)
      3'd0:    c = 23'd5368709;
      3'd1:    c = 23'd4294967;
      3'd2:    c = 23'd3214796;
      3'd3:    c = 23'd2147484;
      3'd4:    c = 23'd1073742;
      3'd5:    c = 23'd536871;
      3'd6:    c = 23'd268435;
      default: c = 23'd134218;
    endcase
    return c;
  endfunction

endpackage

[sv/range_and_light_result_with_auto_gain_top.sv]
// Top level of the range and ambient-light result processor with gain ranging.
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------------------------
//  in        sink       in_valid_i / in_ready_o  cmd, range_raw, range_status, light_count
//  out       source     out_valid_o/out_ready_i  kind, valid, timeout, distance, error,
//                                                lux, gain used, next gain
//  cfg       APB slave  psel/penable/pready      range_scale @0x0, low_count_threshold @0x4
//
// One word is accepted per cycle unless both registers are full; each result passes
// through the input register, then the result register behind the lux multiplier.
// The gain ladder steps at acceptance, so back-to-back light words see each
// other's gain. Reset sets gain 1x, scale 1, threshold 10000.
// When the output stalls, one more word is held in the input register; the
// input stalls only when both registers are full.
module range_and_light_result_with_auto_gain_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // measurement words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  range_raw_i,
  input  logic [7:0]  range_status_i,
  input  logic [15:0] light_count_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic        result_valid_o,
  output logic        tmo_flag_o,
  output logic [9:0]  distance_mm_o,
  output logic [3:0]  range_error_o,
  output logic [22:0] lux_q8_o,
  output logic [2:0]  gain_used_o,
  output logic [2:0]  gain_after_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rlag_pkg::*;

  // Configuration registers.
  logic [1:0]  range_scale_q;
  logic [15:0] low_thresh_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_scale_q <= RANGE_SCALE_RESET;
      low_thresh_q  <= LOW_THRESH_RESET;
    end else if (cfg_wr) begin
      // A zero scale is meaningless: hold the old one.
      if (paddr[2] == REG_RANGE_SCALE) begin
        if (pwdata[1:0] != 2'd0) range_scale_q <= pwdata[1:0];
      end else begin
        low_thresh_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_LOW_THRESH) prdata = {16'd0, low_thresh_q};
    else                            prdata = {30'd0, range_scale_q};
  end

  // Handshakes: the input register advances into the result register whenever
  // the result register is empty or being drained.
  logic    stage_valid_q;
  stage_t  stage_q;
  stage_t  stage_d;
  logic    out_valid_q;
  result_t result_q;
  result_t result_d;
  logic    in_acc;
  logic    stage_adv;
  logic [2:0] gain_q;
  logic [2:0] gain_d;

  assign stage_adv  = !out_valid_q || out_ready_i;
  assign in_ready_o = !stage_valid_q || stage_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Gain ladder: step down on a saturated count, up on a dim one.
  always_comb begin
    gain_d = gain_q;
    if (cmd_e'(cmd_i) == CMD_LIGHT_DONE) begin
      if (light_count_i == COUNT_SATURATED) begin
        if (gain_q != GAIN_BOTTOM) gain_d = gain_q - 3'd1;
      end else if (light_count_i < low_thresh_q) begin
        if (gain_q != GAIN_TOP) gain_d = gain_q + 3'd1;
      end
    end
  end

  always_comb begin
    stage_d.cmd          = cmd_e'(cmd_i);
    stage_d.range_raw    = range_raw_i;
    stage_d.range_status = range_status_i;
    stage_d.light_count  = light_count_i;
    stage_d.range_scale  = range_scale_q;
    stage_d.gain_used    = gain_q;
    stage_d.gain_after   = gain_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q        <= GAIN_BOTTOM;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        gain_q        <= gain_d;
        stage_valid_q <= 1'b1;
      end else if (stage_adv) begin
        stage_valid_q <= 1'b0;
      end
      if (stage_adv) out_valid_q <= stage_valid_q;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) stage_q <= stage_d;
    if (stage_adv && stage_valid_q) result_q <= result_d;
  end

  rlag_calc u_calc (
    .stage_i  (stage_q),
    .result_o (result_d)
  );

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = result_q.result_kind;
  assign result_valid_o = result_q.result_valid;
  assign tmo_flag_o     = result_q.tmo_flag;
  assign distance_mm_o  = result_q.distance_mm;
  assign range_error_o  = result_q.range_error;
  assign lux_q8_o       = result_q.lux_q8;
  assign gain_used_o    = result_q.gain_used;
  assign gain_after_o   = result_q.gain_after;

`ifndef SYNTHESIS
  // Gain moves only on an accepted light-done word.
  a_gain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && (cmd_e'(cmd_i) == CMD_LIGHT_DONE)) |=> $stable(gain_q))
    else $error("gain changed without a light measurement");

  // Gain moves at most one ladder step per word.
  a_gain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (gain_q == $past(gain_q)) || (gain_q == 3'($past(gain_q) + 3'd1)) ||
               (gain_q == 3'($past(gain_q) - 3'd1)))
    else $error("gain jumped more than one step");

  // Range scale never holds zero.
  a_scale_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_scale_q != 2'd0)
    else $error("range scale is zero");

  // Both registers full with output stalled: input must stall.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline full");
`endif

endmodule

[sv/rlag_calc.sv]
// Result formatting: distance, error code and lux from one registered measurement.
module rlag_calc (
  input  rlag_pkg::stage_t  stage_i,
  output rlag_pkg::result_t result_o
);
  import rlag_pkg::*;

  logic [38:0] lux_prod;
  logic [9:0]  range_mm;
  logic [3:0]  err;

  assign lux_prod = 39'(stage_i.light_count) * 39'(lux_coef(stage_i.gain_used));
  assign range_mm = 10'(stage_i.range_raw) * 10'(stage_i.range_scale);
  assign err      = stage_i.range_status[7:4];

  always_comb begin
    result_o              = '0;
    result_o.gain_used    = stage_i.gain_used;
    result_o.gain_after   = stage_i.gain_used;
    case (stage_i.cmd)
      CMD_RANGE_DONE: begin
        // Error nibble set: drop the distance, keep the code.
        if (err == 4'd0) begin
          result_o.result_valid = 1'b1;
          result_o.distance_mm  = range_mm;
        end else begin
          result_o.range_error  = err;
        end
      end
      CMD_RANGE_TIMEOUT: begin
        result_o.tmo_flag = 1'b1;
      end
      CMD_LIGHT_DONE: begin
        result_o.result_kind  = 1'b1;
        result_o.result_valid = 1'b1;
        result_o.lux_q8       = lux_prod[38:16];
        result_o.gain_after   = stage_i.gain_after;
      end
      default: begin
        result_o.result_kind = 1'b1;
        result_o.tmo_flag    = 1'b1;
      end
    endcase
  end

endmodule
